FILE: src/icaf_pkg.sv
// shared types, constants and the arctangent table of the attitude filter
package icaf_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int TABLE_LEN           = 24;
    localparam int PERIOD_W            = 24;
    localparam int GAIN_W              = 17;
    localparam int CFG_W               = 24;
    localparam int ANGLE_W             = 32;
    localparam int PROD_W              = 40;
    localparam int BLEND_W             = 50;
    localparam int CXY_W               = 40;
    localparam int CZ_W                = 36;
    localparam int CNT_W               = 5;

    localparam logic [GAIN_W-1:0] GAIN_ONE      = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET    = 17'd58982;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd83886;
    localparam logic signed [CZ_W-1:0] HALF_TURN = 36'sd3019898880;

    localparam logic [0:0] REG_BLEND_GAIN    = 1'b0;
    localparam logic [0:0] REG_SAMPLE_PERIOD = 1'b1;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } imu_in_t;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] yaw_angle;
    } imu_out_t;

    // round(atan(2^-i) * 180/pi * 2^24)
    function automatic logic signed [CZ_W-1:0] atan_q24(input logic [CNT_W-1:0] i);
        logic signed [CZ_W-1:0] r;
        case (i)
            5'd0:    r = 36'sd754974720;
            5'd1:    r = 36'sd445687602;
            5'd2:    r = 36'sd235489088;
            5'd3:    r = 36'sd119537938;
            5'd4:    r = 36'sd60000934;
            5'd5:    r = 36'sd30029717;
            5'd6:    r = 36'sd15018523;
            5'd7:    r = 36'sd7509720;
            5'd8:    r = 36'sd3754917;
            5'd9:    r = 36'sd1877466;
            5'd10:   r = 36'sd938734;
            5'd11:   r = 36'sd469367;
            5'd12:   r = 36'sd234684;
            5'd13:   r = 36'sd117342;
            5'd14:   r = 36'sd58671;
            5'd15:   r = 36'sd29335;
            5'd16:   r = 36'sd14668;
            5'd17:   r = 36'sd7334;
            5'd18:   r = 36'sd3667;
            5'd19:   r = 36'sd1833;
            5'd20:   r = 36'sd917;
            5'd21:   r = 36'sd458;
            5'd22:   r = 36'sd229;
            5'd23:   r = 36'sd115;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [ANGLE_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

FILE: src/imu_complementary_attitude_filter.sv
// complementary attitude filter: bit-serial gyro and blend products, iterative cordic
//
//  channel | signals                          | beat
//  in      | in_valid in_ready in_data        | one six-axis sample
//  out     | out_valid out_ready out_data     | roll, pitch, yaw angles
//  cfg     | cfg_write cfg_index cfg_data     | one register write
//
// during an input beat the gyro products take one period bit per cycle (24 bits)
// while the cordic steps run alongside them, then the blend takes one gain bit per
// cycle (17 bits) on both weights
// reset clears the angle estimates and loads the default gain and period
// in_ready is high in idle even while a result waits on out_ready; the next result
// waits for the output register to drain
module imu_complementary_attitude_filter
    import icaf_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  imu_in_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output imu_out_t         out_data,
    input  logic             cfg_write,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int STEPS_EFF = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SH        = 24 - ANGLE_FRAC_BITS;
    localparam logic signed [PROD_W:0] GYRO_RND = (41'sd1 <<< SH) >>> 1;
    localparam logic signed [CZ_W:0]   Z_RND    = (37'sd1 <<< SH) >>> 1;
    localparam logic signed [BLEND_W:0] BL_RND  = 51'sd32768;
    localparam logic [CNT_W-1:0] RUN_LAST   = CNT_W'(PERIOD_W);
    localparam logic [CNT_W-1:0] BLEND_LAST = CNT_W'(GAIN_W);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_BLEND = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic signed [ANGLE_W-1:0] est_reg [3];

    // gyro lanes: roll, pitch, yaw
    logic signed [PROD_W-1:0] gacc_reg [3];
    logic signed [PROD_W-1:0] gmc_reg [3];
    logic [PERIOD_W-1:0] per_sr_reg;

    // cordic lanes: pitch, roll
    logic signed [CXY_W-1:0] cx_reg [2];
    logic signed [CXY_W-1:0] cy_reg [2];
    logic signed [CZ_W-1:0]  cz_reg [2];
    logic [1:0] czero_reg;

    // blend lanes: roll, pitch, yaw
    logic signed [BLEND_W-1:0] bacc_reg [3];
    logic signed [BLEND_W-1:0] bmg_reg [3];
    logic signed [BLEND_W-1:0] bma_reg [3];
    logic [GAIN_W-1:0] g_sr_reg, ng_sr_reg;

    imu_out_t res_reg;
    logic out_valid_reg;
    imu_out_t out_reg;

    logic in_acc;
    logic signed [16:0] ini_y [2];
    logic signed [16:0] ini_x;
    logic signed [CXY_W-1:0] cx_next [2];
    logic signed [CXY_W-1:0] cy_next [2];
    logic signed [CZ_W-1:0]  cz_next [2];
    logic signed [CXY_W-1:0] run_x [2];
    logic signed [CXY_W-1:0] run_y [2];
    logic signed [CZ_W-1:0]  run_z [2];
    logic signed [ANGLE_W-1:0] gyro_ang [3];
    logic signed [ANGLE_W-1:0] accel_ang [2];
    logic signed [BLEND_W-1:0] bl_res_w [3];
    logic signed [ANGLE_W-1:0] bl_res [3];
    logic [GAIN_W-1:0] g_eff;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign g_eff     = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;

    // cordic start: fold the left half plane onto the right
    always_comb
    begin
        ini_y[0] = -17'(in_data.accel_x);
        ini_y[1] = 17'(in_data.accel_y);
        ini_x    = 17'(in_data.accel_z);
        for (int l = 0; l < 2; l++)
        begin
            if (ini_x < 0)
            begin
                cx_next[l] = CXY_W'(-ini_x) <<< 20;
                cy_next[l] = CXY_W'(-ini_y[l]) <<< 20;
                cz_next[l] = (ini_y[l] >= 0) ? HALF_TURN : -HALF_TURN;
            end
            else
            begin
                cx_next[l] = CXY_W'(ini_x) <<< 20;
                cy_next[l] = CXY_W'(ini_y[l]) <<< 20;
                cz_next[l] = '0;
            end
        end
    end

    // one cordic micro-rotation per cycle
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            run_x[l] = cx_reg[l];
            run_y[l] = cy_reg[l];
            run_z[l] = cz_reg[l];
            if (cnt_reg < CNT_W'(STEPS_EFF))
            begin
                if (cy_reg[l] < 0)
                begin
                    run_x[l] = cx_reg[l] - (cy_reg[l] >>> cnt_reg);
                    run_y[l] = cy_reg[l] + (cx_reg[l] >>> cnt_reg);
                    run_z[l] = cz_reg[l] - atan_q24(cnt_reg);
                end
                else
                begin
                    run_x[l] = cx_reg[l] + (cy_reg[l] >>> cnt_reg);
                    run_y[l] = cy_reg[l] - (cx_reg[l] >>> cnt_reg);
                    run_z[l] = cz_reg[l] + atan_q24(cnt_reg);
                end
            end
        end
    end

    // angles at the end of the run phase, and the blend result
    always_comb
    begin
        logic signed [PROD_W:0] gs;
        logic signed [CZ_W:0] zs;
        for (int l = 0; l < 3; l++)
        begin
            gs = (PROD_W+1)'(gacc_reg[l]) + GYRO_RND;
            gs = gs >>> SH;
            gyro_ang[l] = sat32(64'(gs) + 64'(est_reg[l]));
        end
        for (int l = 0; l < 2; l++)
        begin
            zs = (CZ_W+1)'(cz_reg[l]) + Z_RND;
            zs = zs >>> SH;
            accel_ang[l] = czero_reg[l] ? '0 : sat32(64'(zs));
        end
        for (int l = 0; l < 3; l++)
        begin
            bl_res_w[l] = bacc_reg[l];
            bl_res[l] = sat32(64'(((BLEND_W+1)'(bl_res_w[l]) + BL_RND) >>> 16));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_RUN;
            ST_RUN:   if (cnt_reg == RUN_LAST) state_next = ST_BLEND;
            ST_BLEND: if (cnt_reg == BLEND_LAST) state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            gain_reg      <= GAIN_RESET;
            period_reg    <= PERIOD_RESET;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < 3; l++)
                est_reg[l] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BLEND_GAIN:    gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_SAMPLE_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    default:           ;
                endcase
            end
            if (state_reg == ST_IDLE || state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == ST_BLEND && cnt_reg == BLEND_LAST)
            begin
                for (int l = 0; l < 3; l++)
                    est_reg[l] <= bl_res[l];
            end
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            gmc_reg[0] <= PROD_W'(in_data.gyro_x);
            gmc_reg[1] <= PROD_W'(in_data.gyro_y);
            gmc_reg[2] <= PROD_W'(in_data.gyro_z);
            for (int l = 0; l < 3; l++)
                gacc_reg[l] <= '0;
            per_sr_reg <= period_reg;
            for (int l = 0; l < 2; l++)
            begin
                cx_reg[l] <= cx_next[l];
                cy_reg[l] <= cy_next[l];
                cz_reg[l] <= cz_next[l];
                czero_reg[l] <= (ini_x == 0) && (ini_y[l] == 0);
            end
        end
        else if (state_reg == ST_RUN)
        begin
            // one period bit per cycle, lsb first
            for (int l = 0; l < 3; l++)
            begin
                if (per_sr_reg[0])
                    gacc_reg[l] <= gacc_reg[l] + gmc_reg[l];
                gmc_reg[l] <= gmc_reg[l] <<< 1;
            end
            per_sr_reg <= per_sr_reg >> 1;
            for (int l = 0; l < 2; l++)
            begin
                cx_reg[l] <= run_x[l];
                cy_reg[l] <= run_y[l];
                cz_reg[l] <= run_z[l];
            end
            if (cnt_reg == RUN_LAST)
            begin
                bmg_reg[0] <= BLEND_W'(gyro_ang[0]);
                bmg_reg[1] <= BLEND_W'(gyro_ang[1]);
                bmg_reg[2] <= BLEND_W'(gyro_ang[2]);
                bma_reg[0] <= BLEND_W'(accel_ang[1]);
                bma_reg[1] <= BLEND_W'(accel_ang[0]);
                bma_reg[2] <= '0;
                for (int l = 0; l < 3; l++)
                    bacc_reg[l] <= '0;
                g_sr_reg  <= g_eff;
                ng_sr_reg <= GAIN_ONE - g_eff;
            end
        end
        else if (state_reg == ST_BLEND)
        begin
            // one gain bit per cycle on both weights
            for (int l = 0; l < 3; l++)
            begin
                bacc_reg[l] <= bacc_reg[l] + (g_sr_reg[0] ? bmg_reg[l] : '0)
                                           + (ng_sr_reg[0] ? bma_reg[l] : '0);
                bmg_reg[l] <= bmg_reg[l] <<< 1;
                bma_reg[l] <= bma_reg[l] <<< 1;
            end
            g_sr_reg  <= g_sr_reg >> 1;
            ng_sr_reg <= ng_sr_reg >> 1;
            if (cnt_reg == BLEND_LAST)
            begin
                res_reg.roll_angle  <= bl_res[0];
                res_reg.pitch_angle <= bl_res[1];
                res_reg.yaw_angle   <= bl_res[2];
            end
        end
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            out_reg <= res_reg;
    end

endmodule

FILE: bench/testbench.sv
// self-checking bench for the complementary attitude filter: directed, saturation and random samples
module testbench;
    import icaf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    imu_in_t          in_data;
    logic             out_valid;
    logic             out_ready;
    imu_out_t         out_data;
    logic             cfg_write;
    logic [0:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    imu_complementary_attitude_filter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int FRAC = ANGLE_FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 1500000;

    // predictor state
    logic [GAIN_W-1:0]   gain_reg;
    logic [PERIOD_W-1:0] period_reg;
    longint              roll_est;
    longint              pitch_est;
    longint              yaw_est;

    imu_out_t pending_angles[$];
    int       errors;
    longint   cycles;
    bit       out_stall_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_half_up(longint v, int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_table(int i);
        longint t[24] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                          15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
                          117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    function automatic longint accel_angle(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        int     n;
        z = 0;
        n = (CORDIC_STEPS_DEF > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS_DEF;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd3019898880 : -64'sd3019898880;
            x = -x;
            y = -y;
        end
        x = x * 1048576;
        y = y * 1048576;
        for (int i = 0; i < n; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_table(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_table(i);
            end
        end
        return clamp32(round_half_up(z, 24 - FRAC));
    endfunction

    function automatic longint integrate(longint prev, longint rate);
        return clamp32(prev + round_half_up(rate * longint'(period_reg), 24 - FRAC));
    endfunction

    function automatic imu_out_t predict_angles(imu_in_t s);
        longint g;
        longint ng;
        longint rg;
        longint pg;
        longint yg;
        longint ra;
        longint pa;
        imu_out_t r;
        g  = (gain_reg > GAIN_ONE) ? 65536 : longint'(gain_reg);
        ng = 65536 - g;
        rg = integrate(roll_est, longint'(s.gyro_x));
        pg = integrate(pitch_est, longint'(s.gyro_y));
        yg = integrate(yaw_est, longint'(s.gyro_z));
        pa = accel_angle(-longint'(s.accel_x), longint'(s.accel_z));
        ra = accel_angle(longint'(s.accel_y), longint'(s.accel_z));
        roll_est  = clamp32(round_half_up(g * rg + ng * ra, 16));
        pitch_est = clamp32(round_half_up(g * pg + ng * pa, 16));
        yaw_est   = clamp32(round_half_up(g * yg, 16));
        r.roll_angle  = roll_est[31:0];
        r.pitch_angle = pitch_est[31:0];
        r.yaw_angle   = yaw_est[31:0];
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin
        imu_out_t e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("unexpected result beat %h", out_data);
                errors++;
            end
            else
            begin
                e = pending_angles.pop_front();
                if (out_data.roll_angle !== e.roll_angle)
                begin
                    $error("roll_angle exp %0d got %0d", e.roll_angle, out_data.roll_angle);
                    errors++;
                end
                if (out_data.pitch_angle !== e.pitch_angle)
                begin
                    $error("pitch_angle exp %0d got %0d", e.pitch_angle, out_data.pitch_angle);
                    errors++;
                end
                if (out_data.yaw_angle !== e.yaw_angle)
                begin
                    $error("yaw_angle exp %0d got %0d", e.yaw_angle, out_data.yaw_angle);
                    errors++;
                end
            end
        end
        if (out_stall_on)
            out_ready <= ($urandom_range(0, 99) < 60);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high across back-to-back beats, it drops only for a gap and in drain
    task automatic send_sample(imu_in_t s);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        pending_angles.push_back(predict_angles(s));
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] v);
        repeat (60) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_BLEND_GAIN)
            gain_reg = v[GAIN_W-1:0];
        else
            period_reg = v;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic imu_in_t rand_sample();
        imu_in_t s;
        s = imu_in_t'({$urandom, $urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
            s.accel_x = 16'(int'($urandom_range(0, 15)) - 8);
        if ($urandom_range(0, 5) == 0)
            s.accel_z = '0;
        if ($urandom_range(0, 2) == 0)
        begin
            s.gyro_x = 16'(int'($urandom_range(0, 400)) - 200);
            s.gyro_y = 16'(int'($urandom_range(0, 400)) - 200);
            s.gyro_z = 16'(int'($urandom_range(0, 400)) - 200);
        end
        return s;
    endfunction

    task automatic test_directed();
        imu_in_t s;
        logic signed [15:0] v[5] = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd1, -16'sd1};
        foreach (v[i])
        begin
            s = '{v[i], v[i], v[i], v[i], v[i], v[i]};
            send_sample(s);
        end
        send_sample(imu_in_t'{16'sd0, 16'sd0, -16'sd100, 16'sd0, 16'sd0, 16'sd0});
        send_sample(imu_in_t'{16'sd100, -16'sd50, -16'sd100, 16'sd0, 16'sd0, 16'sd0});
        send_sample(imu_in_t'{-16'sd100, 16'sd50, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_sample(imu_in_t'{16'sd0, 16'sd0, 16'sd0, 16'sd10, -16'sd10, 16'sd5});
        drain();
    endtask

    // saturation: full period, full gyro weight, extreme rates
    task automatic test_saturation();
        write_reg(REG_BLEND_GAIN, 24'd65536);
        write_reg(REG_SAMPLE_PERIOD, 24'hffffff);
        repeat (6)
            send_sample(imu_in_t'{16'sd0, 16'sd0, 16'sd1, 16'sh7fff, -16'sh8000, 16'sh7fff});
        repeat (6)
            send_sample(imu_in_t'{16'sd0, 16'sd0, 16'sd1, -16'sh8000, 16'sh7fff, -16'sh8000});
        drain();
        write_reg(REG_BLEND_GAIN, 24'h1ffff);  // above one, clamped
        write_reg(REG_SAMPLE_PERIOD, 24'd0);
        repeat (3) send_sample(rand_sample());
        drain();
    endtask

    task automatic test_random(int n);
        int rounds;
        logic [CFG_W-1:0] gains[5] = '{24'd0, 24'd58982, 24'd32768, 24'd65535, 24'd131071};
        rounds = 5;
        for (int k = 0; k < rounds; k++)
        begin
            write_reg(REG_BLEND_GAIN, gains[k]);
            write_reg(REG_SAMPLE_PERIOD, (k == 0) ? 24'd83886 : 24'($urandom));
            out_stall_on = (k % 2 == 1);
            for (int i = 0; i < n / rounds; i++)
                send_sample(rand_sample());
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        out_stall_on = 1'b1;
        gain_reg = GAIN_RESET;
        period_reg = PERIOD_RESET;
        roll_est = 0;
        pitch_est = 0;
        yaw_est = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_random(1400);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: files.f
src/icaf_pkg.sv
src/imu_complementary_attitude_filter.sv
bench/testbench.sv
